// ----- hdl/gexp_pkg.sv -----
// Shared types, constants and helper functions for the grid exploration block.
// No dependencies; used by gexp_ctrl, gexp_dp and grid_explore_no_backtrack.
package gexp_pkg;

    localparam int GEXP_GRID_SIDE = 64;

    // Field widths
    localparam int POS_W   = 6;
    localparam int HEAD_W  = 2;
    localparam int RAND_W  = 16;
    localparam int MOVE_W  = 2;
    localparam int COUNT_W = 13;
    localparam int DIM_W   = 7;
    localparam int COORD_W = 8;  // signed neighbour coordinate, -1 .. 64

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_TOTAL   = 2'd2;

    localparam logic [DIM_W-1:0]   COLUMNS_RESET = 7'd64;
    localparam logic [DIM_W-1:0]   ROWS_RESET    = 7'd64;
    localparam logic [COUNT_W-1:0] TOTAL_RESET   = 13'd0;

    // Bitmap entry layout
    localparam int MAP_W     = 2;
    localparam int MAP_OBST  = 0;
    localparam int MAP_VISIT = 1;

    // Headings
    localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd0;
    localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd1;
    localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd2;
    localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd3;

    // Move codes
    localparam logic [MOVE_W-1:0] MOVE_TURN_LEFT  = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_AHEAD      = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_TURN_RIGHT = 2'd2;

    typedef enum logic [1:0] {
        CELL_LEFT  = 2'd0,
        CELL_FRONT = 2'd1,
        CELL_RIGHT = 2'd2,
        CELL_HERE  = 2'd3
    } cell_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_LAST,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic  clear;     // clearing sweep, one entry per cycle
        logic  capture;   // register the input beat
        logic  issue;     // read the selected cell
        cell_t target;
        logic  update;    // read data back: write back and count
        logic  load_out;  // load result register
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_full;
    } status_t;

    function automatic logic signed [1:0] step_dx(input logic [HEAD_W-1:0] h);
        logic signed [1:0] d;
        case (h)
            HEAD_LEFT:  d = -2'sd1;
            HEAD_RIGHT: d = 2'sd1;
            default:    d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [1:0] step_dy(input logic [HEAD_W-1:0] h);
        logic signed [1:0] d;
        case (h)
            HEAD_UP:   d = 2'sd1;
            HEAD_DOWN: d = -2'sd1;
            default:   d = 2'sd0;
        endcase
        return d;
    endfunction

    // 16 = 4 = 1 (mod 3): fold digits, then two small corrections
    function automatic logic [1:0] mod3_16(input logic [RAND_W-1:0] v);
        logic [5:0] s;
        logic [3:0] t;
        s = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]) + 6'(v[15:12]);
        t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
        if (t >= 4'd6) t = t - 4'd6;
        if (t >= 4'd3) t = t - 4'd3;
        return t[1:0];
    endfunction

    // Choice table: left, right, forward
    function automatic logic [MOVE_W-1:0] pick_move(input logic [1:0] idx);
        logic [MOVE_W-1:0] m;
        case (idx)
            2'd0:    m = MOVE_TURN_LEFT;
            2'd1:    m = MOVE_TURN_RIGHT;
            2'd2:    m = MOVE_AHEAD;
            default: m = MOVE_TURN_LEFT;
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/gexp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gexp_ram #(
    parameter int WIDTH  = 2,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/gexp_ctrl.sv -----
// Controller for the grid exploration block: clearing sweep and per-step sequence.
// Depends on gexp_pkg.
module gexp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  gexp_pkg::status_t status,
    output gexp_pkg::cmd_t    cmd
);

    gexp_pkg::state_t state_reg, state_next;
    logic [1:0]       cell_reg, cell_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gexp_pkg::ST_CLEAR;
            cell_reg  <= gexp_pkg::CELL_LEFT;
        end else begin
            state_reg <= state_next;
            cell_reg  <= cell_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cell_next  = cell_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        cmd.target = gexp_pkg::cell_t'(cell_reg);
        unique case (state_reg)
            gexp_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (status.clear_last) begin
                    state_next = gexp_pkg::ST_IDLE;
                end
            end
            gexp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    cell_next   = gexp_pkg::CELL_LEFT;
                    state_next  = gexp_pkg::ST_RUN;
                end
            end
            gexp_pkg::ST_RUN: begin
                cmd.issue  = 1'b1;
                cmd.update = (cell_reg != gexp_pkg::CELL_LEFT);
                cell_next  = cell_reg + 2'd1;
                if (cell_reg == gexp_pkg::CELL_HERE) begin
                    state_next = gexp_pkg::ST_LAST;
                end
            end
            gexp_pkg::ST_LAST: begin
                cmd.update = 1'b1;
                if (!status.out_full) begin
                    cmd.load_out = 1'b1;
                    state_next   = gexp_pkg::ST_IDLE;
                end else begin
                    state_next = gexp_pkg::ST_OUT;
                end
            end
            gexp_pkg::ST_OUT: begin
                if (!status.out_full) begin
                    cmd.load_out = 1'b1;
                    state_next   = gexp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gexp_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- hdl/gexp_dp.sv -----
// Datapath: input registers, neighbour addressing, bitmap RAM, counter, result register.
// Depends on gexp_pkg and gexp_ram.
module gexp_dp #(
    parameter int GRID_SIDE = gexp_pkg::GEXP_GRID_SIDE
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gexp_pkg::cmd_t                      cmd,
    output gexp_pkg::status_t                   status,
    input  logic [gexp_pkg::DIM_W-1:0]          grid_columns,
    input  logic [gexp_pkg::DIM_W-1:0]          grid_rows,
    input  logic [gexp_pkg::COUNT_W-1:0]        obstacle_total,
    input  logic [gexp_pkg::POS_W-1:0]          s_pos_x,
    input  logic [gexp_pkg::POS_W-1:0]          s_pos_y,
    input  logic [gexp_pkg::HEAD_W-1:0]         s_heading,
    input  logic                                s_sense_left,
    input  logic                                s_sense_front,
    input  logic                                s_sense_right,
    input  logic [gexp_pkg::RAND_W-1:0]         s_random_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gexp_pkg::MOVE_W-1:0]         m_next_move,
    output logic [gexp_pkg::COUNT_W-1:0]        m_found_count,
    output logic                                m_stop,
    output logic                                m_front_free
);

    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [8:0] SIDE9 = 9'(GRID_SIDE);
    localparam int CW = gexp_pkg::COORD_W;
    localparam logic [gexp_pkg::COUNT_W-1:0] COUNT_ONE =
        {{(gexp_pkg::COUNT_W-1){1'b0}}, 1'b1};

    // Captured step
    logic [gexp_pkg::POS_W-1:0]  x_reg, y_reg;
    logic [gexp_pkg::HEAD_W-1:0] h_reg;
    logic [2:0]                  sense_reg;  // left, front, right
    logic [gexp_pkg::RAND_W-1:0] rnd_reg;

    // Read pipeline
    logic [ADDR_W-1:0]   p_addr_reg;
    gexp_pkg::cell_t     p_cell_reg;
    logic                p_ing_reg;
    logic                p_sense_reg;

    logic [ADDR_W-1:0]           clr_addr_reg;
    logic [gexp_pkg::COUNT_W-1:0] count_reg;
    logic                        free_reg, free_next;

    logic                        m_valid_reg;
    logic [gexp_pkg::MOVE_W-1:0] move_reg;
    logic [gexp_pkg::COUNT_W-1:0] found_reg;
    logic                        stop_reg;
    logic                        ff_reg;

    // Neighbour lookup
    logic [gexp_pkg::HEAD_W-1:0] h_sel;
    logic signed [1:0]           dx, dy;
    logic signed [CW-1:0]        nx, ny;
    logic [gexp_pkg::DIM_W-1:0]  cols_eff, rows_eff;
    logic                        ing;
    logic                        sense_sel;
    logic [ADDR_W-1:0]           addr;

    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr;
    logic [gexp_pkg::MAP_W-1:0]     ram_wdata, ram_rdata;
    logic                           new_obst;
    logic [1:0]                     move_idx;

    always_comb begin
        cols_eff = ({2'b00, grid_columns} > SIDE9) ? SIDE9[6:0] : grid_columns;
        rows_eff = ({2'b00, grid_rows} > SIDE9) ? SIDE9[6:0] : grid_rows;
        sense_sel = 1'b0;
        case (cmd.target)
            gexp_pkg::CELL_LEFT: begin
                h_sel     = h_reg + 2'd1;
                sense_sel = sense_reg[0];
            end
            gexp_pkg::CELL_FRONT: begin
                h_sel     = h_reg;
                sense_sel = sense_reg[1];
            end
            gexp_pkg::CELL_RIGHT: begin
                h_sel     = h_reg + 2'd3;
                sense_sel = sense_reg[2];
            end
            default: begin
                h_sel = h_reg;
            end
        endcase
        if (cmd.target == gexp_pkg::CELL_HERE) begin
            dx = 2'sd0;
            dy = 2'sd0;
        end else begin
            dx = gexp_pkg::step_dx(h_sel);
            dy = gexp_pkg::step_dy(h_sel);
        end
        nx = $signed({2'b00, x_reg}) + $signed({{(CW-2){dx[1]}}, dx});
        ny = $signed({2'b00, y_reg}) + $signed({{(CW-2){dy[1]}}, dy});
        ing = !nx[CW-1] && !ny[CW-1] && (nx[6:0] < cols_eff) && (ny[6:0] < rows_eff);
        addr = ADDR_W'({25'd0, ny[6:0]} * 32'(GRID_SIDE) + {25'd0, nx[6:0]});
    end

    // Write-back and clearing sweep
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = p_addr_reg;
        ram_wdata = ram_rdata;
        new_obst  = 1'b0;
        free_next = free_reg;
        if (cmd.clear) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else if (cmd.update) begin
            case (p_cell_reg)
                gexp_pkg::CELL_HERE: begin
                    if (p_ing_reg) begin
                        ram_we = 1'b1;
                        ram_wdata[gexp_pkg::MAP_VISIT] = 1'b1;
                    end
                end
                default: begin
                    if (p_ing_reg && p_sense_reg && !ram_rdata[gexp_pkg::MAP_OBST]) begin
                        ram_we   = 1'b1;
                        new_obst = 1'b1;
                        ram_wdata[gexp_pkg::MAP_OBST] = 1'b1;
                    end
                    if (p_cell_reg == gexp_pkg::CELL_FRONT) begin
                        free_next = p_ing_reg && !p_sense_reg
                                    && !ram_rdata[gexp_pkg::MAP_OBST]
                                    && !ram_rdata[gexp_pkg::MAP_VISIT];
                    end
                end
            endcase
        end
    end

    gexp_ram #(
        .WIDTH (gexp_pkg::MAP_W),
        .DEPTH (CELLS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg     <= s_pos_x;
            y_reg     <= s_pos_y;
            h_reg     <= s_heading;
            sense_reg <= {s_sense_right, s_sense_front, s_sense_left};
            rnd_reg   <= s_random_value;
        end
        if (cmd.issue) begin
            p_addr_reg  <= addr;
            p_cell_reg  <= cmd.target;
            p_ing_reg   <= ing;
            p_sense_reg <= sense_sel;
        end
        free_reg <= free_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end else begin
            if (cmd.clear) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (new_obst && count_reg != '1) begin
                count_reg <= count_reg + COUNT_ONE;
            end
        end
    end

    assign move_idx = free_reg ? gexp_pkg::mod3_16(rnd_reg) : {1'b0, rnd_reg[0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            move_reg  <= gexp_pkg::pick_move(move_idx);
            found_reg <= count_reg;
            stop_reg  <= (count_reg == obstacle_total);
            ff_reg    <= free_reg;
        end
    end

    assign status.clear_last = (clr_addr_reg == ADDR_W'(CELLS - 1));
    assign status.out_full   = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_next_move   = move_reg;
    assign m_found_count = found_reg;
    assign m_stop        = stop_reg;
    assign m_front_free  = ff_reg;

endmodule

// ----- hdl/grid_explore_no_backtrack.sv -----
// Top level of the grid exploration planner: configuration registers, controller, datapath.
// Depends on gexp_pkg, gexp_ctrl, gexp_dp (and through it gexp_ram).
//
// One input beat per robot step gives one result beat. After reset the block
// runs a clearing pass over the obstacle/visited bitmap, all GRID_SIDE*GRID_SIDE
// entries (4096 at the default), with s_ready low; configuration writes are
// taken throughout. A step then runs from acceptance to the next possible
// acceptance as follows: capture of the beat, four lookups of the left, front,
// right and current cells through the single read port of the bitmap RAM (each
// write-back overlaps the next read), and the last write-back and loading of
// the result register. The result register frees the input side: a new step
// may start while a result waits on m_ready, and only holds at its end if the
// previous result is still untaken.
module grid_explore_no_backtrack #(
    parameter int GRID_SIDE = gexp_pkg::GEXP_GRID_SIDE
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [gexp_pkg::COUNT_W-1:0]    cfg_data,
    // step beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [gexp_pkg::POS_W-1:0]      s_pos_x,
    input  logic [gexp_pkg::POS_W-1:0]      s_pos_y,
    input  logic [gexp_pkg::HEAD_W-1:0]     s_heading,
    input  logic                            s_sense_left,
    input  logic                            s_sense_front,
    input  logic                            s_sense_right,
    input  logic [gexp_pkg::RAND_W-1:0]     s_random_value,
    // result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [gexp_pkg::MOVE_W-1:0]     m_next_move,
    output logic [gexp_pkg::COUNT_W-1:0]    m_found_count,
    output logic                            m_stop,
    output logic                            m_front_free
);

    logic [gexp_pkg::DIM_W-1:0]   cols_reg, rows_reg;
    logic [gexp_pkg::COUNT_W-1:0] total_reg;

    gexp_pkg::cmd_t    cmd;
    gexp_pkg::status_t status;

    // Registers are always writable; an index beyond the list is dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg  <= gexp_pkg::COLUMNS_RESET;
            rows_reg  <= gexp_pkg::ROWS_RESET;
            total_reg <= gexp_pkg::TOTAL_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gexp_pkg::CFG_COLUMNS: cols_reg  <= cfg_data[gexp_pkg::DIM_W-1:0];
                gexp_pkg::CFG_ROWS:    rows_reg  <= cfg_data[gexp_pkg::DIM_W-1:0];
                gexp_pkg::CFG_TOTAL:   total_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencing: clear sweep, capture, four cell lookups, write-back, result load
    gexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Bitmap, obstacle counter and result register
    gexp_dp #(
        .GRID_SIDE (GRID_SIDE)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .grid_columns   (cols_reg),
        .grid_rows      (rows_reg),
        .obstacle_total (total_reg),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_heading      (s_heading),
        .s_sense_left   (s_sense_left),
        .s_sense_front  (s_sense_front),
        .s_sense_right  (s_sense_right),
        .s_random_value (s_random_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_move    (m_next_move),
        .m_found_count  (m_found_count),
        .m_stop         (m_stop),
        .m_front_free   (m_front_free)
    );

endmodule

// ----- test/gexp_checker.sv -----
// Scoreboard for grid_explore_no_backtrack: watches config, step and result beats,
// keeps its own obstacle/visited maps and compares every result beat field by field.
// Depends on gexp_pkg for widths, register indexes, headings and move codes.
module gexp_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [gexp_pkg::COUNT_W-1:0] cfg_data,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [gexp_pkg::POS_W-1:0]  s_pos_x,
    input  logic [gexp_pkg::POS_W-1:0]  s_pos_y,
    input  logic [gexp_pkg::HEAD_W-1:0] s_heading,
    input  logic                        s_sense_left,
    input  logic                        s_sense_front,
    input  logic                        s_sense_right,
    input  logic [gexp_pkg::RAND_W-1:0] s_random_value,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [gexp_pkg::MOVE_W-1:0] m_next_move,
    input  logic [gexp_pkg::COUNT_W-1:0] m_found_count,
    input  logic                        m_stop,
    input  logic                        m_front_free,
    output int                          fail_count,
    output int                          pending,
    output logic [gexp_pkg::COUNT_W-1:0] found
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE  = gexp_pkg::GEXP_GRID_SIDE;
    localparam int CELLS = SIDE * SIDE;
    localparam logic [gexp_pkg::COUNT_W-1:0] COUNT_SAT = '1;
    localparam logic [gexp_pkg::COUNT_W-1:0] COUNT_ONE =
        {{(gexp_pkg::COUNT_W-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic [gexp_pkg::MOVE_W-1:0]  move;
        logic [gexp_pkg::COUNT_W-1:0] count;
        logic                         stop;
        logic                         front_free;
    } step_result_t;

    bit                           obstacle_cells [CELLS];
    bit                           visited_cells  [CELLS];
    logic [gexp_pkg::COUNT_W-1:0] found_q;
    logic [gexp_pkg::DIM_W-1:0]   columns_q;
    logic [gexp_pkg::DIM_W-1:0]   rows_q;
    logic [gexp_pkg::COUNT_W-1:0] total_q;
    step_result_t                 planned_moves [$];

    function automatic int span(input logic [gexp_pkg::DIM_W-1:0] r);
        return (r > SIDE) ? SIDE : int'(r);
    endfunction

    function automatic bit on_grid(input int x, input int y);
        return x >= 0 && y >= 0 && x < span(columns_q) && y < span(rows_q);
    endfunction

    function automatic void heading_offset(input logic [gexp_pkg::HEAD_W-1:0] h,
                                           output int dx, output int dy);
        dx = 0;
        dy = 0;
        case (h)
            gexp_pkg::HEAD_UP:    dy = 1;
            gexp_pkg::HEAD_LEFT:  dx = -1;
            gexp_pkg::HEAD_DOWN:  dy = -1;
            gexp_pkg::HEAD_RIGHT: dx = 1;
            default:              dx = 0;
        endcase
    endfunction

    // Off-grid sightings are dropped; each cell counts once, count saturates
    function automatic void note_obstacle(input bit sensed, input int x, input int y);
        if (sensed && on_grid(x, y) && !obstacle_cells[y * SIDE + x]) begin
            obstacle_cells[y * SIDE + x] = 1'b1;
            if (found_q != COUNT_SAT)
                found_q = found_q + COUNT_ONE;
        end
    endfunction

    // Choice order: left, right, forward
    function automatic logic [gexp_pkg::MOVE_W-1:0] move_for(input int slot);
        case (slot)
            0:       return gexp_pkg::MOVE_TURN_LEFT;
            1:       return gexp_pkg::MOVE_TURN_RIGHT;
            default: return gexp_pkg::MOVE_AHEAD;
        endcase
    endfunction

    function automatic step_result_t plan_step(
        input logic [gexp_pkg::POS_W-1:0]  px,
        input logic [gexp_pkg::POS_W-1:0]  py,
        input logic [gexp_pkg::HEAD_W-1:0] h,
        input logic                        sl,
        input logic                        sf,
        input logic                        sr,
        input logic [gexp_pkg::RAND_W-1:0] rnd
    );
        int                          xi, yi, ldx, ldy, fdx, fdy, rdx, rdy, fx, fy;
        logic [gexp_pkg::HEAD_W-1:0] hl, hr;
        bit                          free;
        step_result_t                res;
        xi = int'(px);
        yi = int'(py);
        hl = h + 2'd1;
        hr = h + 2'd3;
        heading_offset(h, fdx, fdy);
        heading_offset(hl, ldx, ldy);
        heading_offset(hr, rdx, rdy);
        fx = xi + fdx;
        fy = yi + fdy;
        note_obstacle(sl, xi + ldx, yi + ldy);
        note_obstacle(sf, fx, fy);
        note_obstacle(sr, xi + rdx, yi + rdy);
        if (on_grid(xi, yi))
            visited_cells[yi * SIDE + xi] = 1'b1;
        free = on_grid(fx, fy) && !obstacle_cells[fy * SIDE + fx]
               && !visited_cells[fy * SIDE + fx];
        res.move       = free ? move_for(int'(rnd % 3)) : move_for(int'(rnd % 2));
        res.count      = found_q;
        res.stop       = (found_q == total_q);
        res.front_free = free;
        return res;
    endfunction

    always @(posedge aclk) begin : watch_beats
        step_result_t want;
        if (!aresetn) begin
            foreach (obstacle_cells[i]) obstacle_cells[i] = 1'b0;
            foreach (visited_cells[i]) visited_cells[i] = 1'b0;
            found_q   = '0;
            columns_q = gexp_pkg::COLUMNS_RESET;
            rows_q    = gexp_pkg::ROWS_RESET;
            total_q   = gexp_pkg::TOTAL_RESET;
            planned_moves.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (planned_moves.size() == 0) begin
                    $error("result beat with no step outstanding");
                    fail_count++;
                end else begin
                    want = planned_moves.pop_front();
                    if (m_next_move !== want.move) begin
                        $error("next_move: expected %0d, got %0d", want.move, m_next_move);
                        fail_count++;
                    end
                    if (m_found_count !== want.count) begin
                        $error("found_count: expected %0d, got %0d", want.count,
                               m_found_count);
                        fail_count++;
                    end
                    if (m_stop !== want.stop) begin
                        $error("stop: expected %0d, got %0d", want.stop, m_stop);
                        fail_count++;
                    end
                    if (m_front_free !== want.front_free) begin
                        $error("front_free: expected %0d, got %0d", want.front_free,
                               m_front_free);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    gexp_pkg::CFG_COLUMNS: columns_q = cfg_data[gexp_pkg::DIM_W-1:0];
                    gexp_pkg::CFG_ROWS:    rows_q    = cfg_data[gexp_pkg::DIM_W-1:0];
                    gexp_pkg::CFG_TOTAL:   total_q   = cfg_data;
                    default:               ;
                endcase
            end
            if (s_valid && s_ready)
                planned_moves.insert(planned_moves.size(),
                                     plan_step(s_pos_x, s_pos_y, s_heading, s_sense_left,
                                               s_sense_front, s_sense_right,
                                               s_random_value));
        end
        pending = planned_moves.size();
        found   = found_q;
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the grid_explore_no_backtrack testbench: clock, reset, step/config/result drivers,
// watchdog and verdict. Depends on gexp_pkg, the DUT and gexp_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT      = 20000;  // must outlast the clearing pass
    localparam int HOLD_CYCLES     = 150;    // long result stall, fills the block
    localparam int PHASES          = 7;
    localparam int STEPS_PER_PHASE = 64;
    localparam int SETTLE_CYCLES   = 8;      // settle time after the last result
    localparam logic [1:0] CFG_SPARE = 2'd3; // unused index, must be ignored

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index;
    logic [gexp_pkg::COUNT_W-1:0]  cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic [gexp_pkg::POS_W-1:0]    s_pos_x;
    logic [gexp_pkg::POS_W-1:0]    s_pos_y;
    logic [gexp_pkg::HEAD_W-1:0]   s_heading;
    logic                          s_sense_left;
    logic                          s_sense_front;
    logic                          s_sense_right;
    logic [gexp_pkg::RAND_W-1:0]   s_random_value;
    logic                          m_valid;
    logic                          m_ready;
    logic [gexp_pkg::MOVE_W-1:0]   m_next_move;
    logic [gexp_pkg::COUNT_W-1:0]  m_found_count;
    logic                          m_stop;
    logic                          m_front_free;

    int                            fail_count;
    int                            pending;
    logic [gexp_pkg::COUNT_W-1:0]  found_so_far;

    // stimulus controls shared with the result-side process, and the watchdog's idle counter
    bit                            no_gaps;
    bit                            hold_out;
    int                            idle_cycles;

    // robot walk state
    int                            walk_x, walk_y, box_w, box_h;
    logic [gexp_pkg::HEAD_W-1:0]   walk_h;
    int unsigned                   column_plan [PHASES] = '{8, 1, 64, 127, 0, 12, 64};
    int unsigned                   row_plan    [PHASES] = '{8, 64, 1, 127, 0, 5, 64};
    int unsigned                   cols, rows;
    logic [gexp_pkg::COUNT_W-1:0]  cfg_word;
    logic [gexp_pkg::COUNT_W-1:0]  total_word;

    grid_explore_no_backtrack dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_heading      (s_heading),
        .s_sense_left   (s_sense_left),
        .s_sense_front  (s_sense_front),
        .s_sense_right  (s_sense_right),
        .s_random_value (s_random_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_move    (m_next_move),
        .m_found_count  (m_found_count),
        .m_stop         (m_stop),
        .m_front_free   (m_front_free)
    );

    gexp_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_heading      (s_heading),
        .s_sense_left   (s_sense_left),
        .s_sense_front  (s_sense_front),
        .s_sense_right  (s_sense_right),
        .s_random_value (s_random_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_next_move    (m_next_move),
        .m_found_count  (m_found_count),
        .m_stop         (m_stop),
        .m_front_free   (m_front_free),
        .fail_count     (fail_count),
        .pending        (pending),
        .found          (found_so_far)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // One step beat. Inputs move on the falling edge only; a zero gap keeps
    // valid high straight into the next beat so it is never dropped and re-raised.
    task automatic send_step(input logic [gexp_pkg::POS_W-1:0] x,
                             input logic [gexp_pkg::POS_W-1:0] y,
                             input logic [gexp_pkg::HEAD_W-1:0] h, input logic sl,
                             input logic sf, input logic sr,
                             input logic [gexp_pkg::RAND_W-1:0] rnd);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_pos_x        = x;
        s_pos_y        = y;
        s_heading      = h;
        s_sense_left   = sl;
        s_sense_front  = sf;
        s_sense_right  = sr;
        s_random_value = rnd;
        s_valid        = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [gexp_pkg::COUNT_W-1:0] data);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Sender goes quiet until every outstanding result beat is back, then
    // waits out SETTLE_CYCLES so the block can finish its last write-back.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Plausible robot walk inside the box: turn or step forward, random sightings.
    task automatic walk_step();
        int nx, ny;
        send_step(walk_x[gexp_pkg::POS_W-1:0], walk_y[gexp_pkg::POS_W-1:0], walk_h,
                  $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                  $urandom_range(0, 3) == 0, gexp_pkg::RAND_W'($urandom));
        nx = walk_x + gexp_pkg::step_dx(walk_h);
        ny = walk_y + gexp_pkg::step_dy(walk_h);
        case ($urandom_range(0, 3))
            0: walk_h = walk_h + 2'd1;
            1: walk_h = walk_h + 2'd3;
            default: begin
                if (nx >= 0 && ny >= 0 && nx < box_w && ny < box_h) begin
                    walk_x = nx;
                    walk_y = ny;
                end else begin
                    walk_h = walk_h + 2'd1;
                end
            end
        endcase
    endtask

    // Result side: random stalls per beat, plus one long hold-off on request.
    initial begin : result_side
        int gap;
        bit held;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_out && !held) begin
                held    = 1'b1;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        no_gaps        = 1'b0;
        hold_out       = 1'b0;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = gexp_pkg::CFG_COLUMNS;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_pos_x        = '0;
        s_pos_y        = '0;
        s_heading      = gexp_pkg::HEAD_UP;
        s_sense_left   = 1'b0;
        s_sense_front  = 1'b0;
        s_sense_right  = 1'b0;
        s_random_value = '0;
        m_ready        = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        // Directed, at reset config (64x64 grid, zero total).
        // Nothing found yet against a zero total: stop high; fresh front cell free.
        send_step(6'd10, 6'd10, gexp_pkg::HEAD_UP, 1'b0, 1'b0, 1'b0, 16'd0);
        send_step(6'd10, 6'd10, gexp_pkg::HEAD_UP, 1'b0, 1'b0, 1'b0, 16'hFFFF);
        // Corners: sightings off the grid edge are dropped, in-grid ones counted
        send_step(6'd0, 6'd0, gexp_pkg::HEAD_LEFT, 1'b1, 1'b1, 1'b1, 16'd1);
        send_step(6'd0, 6'd0, gexp_pkg::HEAD_DOWN, 1'b1, 1'b1, 1'b1, 16'd2);
        send_step(6'd63, 6'd63, gexp_pkg::HEAD_UP, 1'b1, 1'b1, 1'b1, 16'd3);
        send_step(6'd63, 6'd63, gexp_pkg::HEAD_RIGHT, 1'b1, 1'b1, 1'b1, 16'hFFFE);
        send_step(6'd63, 6'd0, gexp_pkg::HEAD_RIGHT, 1'b1, 1'b1, 1'b1, 16'd5);
        send_step(6'd0, 6'd63, gexp_pkg::HEAD_LEFT, 1'b1, 1'b1, 1'b1, 16'd7);
        // Same sighting again must not count twice
        send_step(6'd0, 6'd0, gexp_pkg::HEAD_LEFT, 1'b1, 1'b1, 1'b1, 16'd4);
        // Front blocked by a fresh obstacle, then front already visited
        send_step(6'd20, 6'd20, gexp_pkg::HEAD_RIGHT, 1'b0, 1'b1, 1'b0, 16'd2);
        send_step(6'd21, 6'd20, gexp_pkg::HEAD_LEFT, 1'b0, 1'b0, 1'b0, 16'd2);
        // Free front with random picking forward
        send_step(6'd30, 6'd30, gexp_pkg::HEAD_RIGHT, 1'b0, 1'b0, 1'b0, 16'd2);
        // Left sensor under every heading
        send_step(6'd40, 6'd40, gexp_pkg::HEAD_UP, 1'b1, 1'b0, 1'b0, 16'h8000);
        send_step(6'd40, 6'd40, gexp_pkg::HEAD_LEFT, 1'b1, 1'b0, 1'b0, 16'h5555);
        send_step(6'd40, 6'd40, gexp_pkg::HEAD_DOWN, 1'b1, 1'b0, 1'b0, 16'hAAAA);
        send_step(6'd40, 6'd40, gexp_pkg::HEAD_RIGHT, 1'b1, 1'b0, 1'b0, 16'h0F0F);
        // Right sensor and everything set in the middle of the grid
        send_step(6'd32, 6'd31, gexp_pkg::HEAD_DOWN, 1'b0, 1'b0, 1'b1, 16'hF0F0);
        send_step(6'd42, 6'd21, gexp_pkg::HEAD_UP, 1'b1, 1'b1, 1'b1, 16'h7FFF);

        // Random phases: each reconfigures the grid while idle, then mostly
        // walks a robot inside the grid (a 4x4 box for a zero size) with some fully random noise steps.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            cols = (p == 5) ? $urandom_range(2, 16) : column_plan[p];
            rows = (p == 5) ? $urandom_range(2, 16) : row_plan[p];
            cfg_word = gexp_pkg::COUNT_W'($urandom);
            cfg_word[gexp_pkg::DIM_W-1:0] = gexp_pkg::DIM_W'(cols);
            write_reg(gexp_pkg::CFG_COLUMNS, cfg_word);
            cfg_word = gexp_pkg::COUNT_W'($urandom);
            cfg_word[gexp_pkg::DIM_W-1:0] = gexp_pkg::DIM_W'(rows);
            write_reg(gexp_pkg::CFG_ROWS, cfg_word);
            // Totals a few above the current count so stop gets crossed; two
            // phases use unreachable extremes.
            case (p)
                3:       total_word = '1;
                5:       total_word = 13'd4096;
                default: total_word = found_so_far
                                      + gexp_pkg::COUNT_W'($urandom_range(0, 5));
            endcase
            write_reg(gexp_pkg::CFG_TOTAL, total_word);
            if (p == 0)
                write_reg(CFG_SPARE, gexp_pkg::COUNT_W'($urandom));
            no_gaps = (p == 2);
            box_w   = (cols == 0) ? 4 : ((cols > gexp_pkg::GEXP_GRID_SIDE)
                                         ? gexp_pkg::GEXP_GRID_SIDE : cols);
            box_h   = (rows == 0) ? 4 : ((rows > gexp_pkg::GEXP_GRID_SIDE)
                                         ? gexp_pkg::GEXP_GRID_SIDE : rows);
            walk_x  = $urandom_range(0, box_w - 1);
            walk_y  = $urandom_range(0, box_h - 1);
            walk_h  = gexp_pkg::HEAD_W'($urandom);
            for (int k = 0; k < STEPS_PER_PHASE; k++) begin
                if (p == 1 && k == 10)
                    hold_out = 1'b1;
                if ($urandom_range(0, 99) < 85)
                    walk_step();
                else
                    send_step(gexp_pkg::POS_W'($urandom), gexp_pkg::POS_W'($urandom),
                              gexp_pkg::HEAD_W'($urandom), 1'($urandom), 1'($urandom),
                              1'($urandom), gexp_pkg::RAND_W'($urandom));
            end
        end

        // Wind down: all results back, then a short settle.
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
